/* sv/sct_pkg.sv */
package sct_pkg;

  // One input item: a byte or the end-of-input command.
  typedef struct packed {
    logic       command;
    logic [7:0] char_in;
  } in_item_t;

  // One token event.
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] char_out;
    logic       last;
  } res_t;

  // Events of one item, at most two, in order.
  typedef struct packed {
    logic [1:0]     num;
    res_t [1:0]     res;
  } lex_out_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_SQ    = 3'd3,
    MODE_DQ    = 3'd4,
    MODE_DQESC = 3'd5,
    MODE_GT    = 3'd6
  } mode_e;

  localparam logic [3:0] KIND_BYTE = 4'd0;
  localparam logic [3:0] KIND_WEND = 4'd1;
  localparam logic [3:0] KIND_PIPE = 4'd2;
  localparam logic [3:0] KIND_SEMI = 4'd3;
  localparam logic [3:0] KIND_IN   = 4'd4;
  localparam logic [3:0] KIND_OUT  = 4'd5;
  localparam logic [3:0] KIND_APP  = 4'd6;
  localparam logic [3:0] KIND_ERR  = 4'd7;
  localparam logic [3:0] KIND_END  = 4'd8;

  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

endpackage

/* sv/sct_lex.sv */
module sct_lex (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sct_pkg::in_item_t  item_i,
  output sct_pkg::lex_out_t  lex_o
);

  sct_pkg::mode_e mode_q, mode_d;

  logic [2:0] slot_v;
  logic [3:0] slot_k [3];
  logic [7:0] slot_c [3];
  logic [7:0] c;
  logic       blank;
  logic       sep;
  logic [1:0] cnt;

  assign c     = item_i.char_in;
  assign blank = (c == sct_pkg::CH_SPACE) ||
                 ((c >= sct_pkg::CH_TAB) && (c <= sct_pkg::CH_CR));
  assign sep   = blank || (c == sct_pkg::CH_PIPE) || (c == sct_pkg::CH_SEMI) ||
                 (c == sct_pkg::CH_LT) || (c == sct_pkg::CH_GT);

  // Lexer mode advances once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sct_pkg::MODE_IDLE;
    end else if (step_i) begin
      mode_q <= mode_d;
    end
  end

  // Up to three candidate events in order; at most two are ever set together.
  always_comb begin
    mode_d = mode_q;
    slot_v = 3'b000;
    for (int i = 0; i < 3; i++) begin
      slot_k[i] = sct_pkg::KIND_BYTE;
      slot_c[i] = 8'h00;
    end
    if (item_i.command) begin
      slot_v[1] = 1'b1;
      slot_k[1] = sct_pkg::KIND_END;
      mode_d    = sct_pkg::MODE_IDLE;
      case (mode_q)
        sct_pkg::MODE_WORD: begin
          slot_v[0] = 1'b1;
          slot_k[0] = sct_pkg::KIND_WEND;
        end
        sct_pkg::MODE_GT: begin
          slot_v[0] = 1'b1;
          slot_k[0] = sct_pkg::KIND_OUT;
        end
        sct_pkg::MODE_ESC, sct_pkg::MODE_SQ, sct_pkg::MODE_DQ,
        sct_pkg::MODE_DQESC: begin
          slot_v[0] = 1'b1;
          slot_k[0] = sct_pkg::KIND_ERR;
        end
        default: begin
        end
      endcase
    end else begin
      case (mode_q)
        sct_pkg::MODE_ESC: begin
          slot_v[2] = 1'b1;
          slot_c[2] = c;
          mode_d    = sct_pkg::MODE_WORD;
        end
        sct_pkg::MODE_SQ: begin
          if (c == sct_pkg::CH_SQ) begin
            mode_d = sct_pkg::MODE_WORD;
          end else begin
            slot_v[2] = 1'b1;
            slot_c[2] = c;
          end
        end
        sct_pkg::MODE_DQ: begin
          if (c == sct_pkg::CH_DQ) begin
            mode_d = sct_pkg::MODE_WORD;
          end else if (c == sct_pkg::CH_BSL) begin
            mode_d = sct_pkg::MODE_DQESC;
          end else begin
            slot_v[2] = 1'b1;
            slot_c[2] = c;
          end
        end
        sct_pkg::MODE_DQESC: begin
          slot_v[2] = 1'b1;
          slot_c[2] = c;
          mode_d    = sct_pkg::MODE_DQ;
        end
        default: begin
          // Idle, inside a word, or after a greater-than.
          if ((mode_q == sct_pkg::MODE_GT) && (c == sct_pkg::CH_GT)) begin
            slot_v[0] = 1'b1;
            slot_k[0] = sct_pkg::KIND_APP;
            mode_d    = sct_pkg::MODE_IDLE;
          end else begin
            if (mode_q == sct_pkg::MODE_GT) begin
              slot_v[0] = 1'b1;
              slot_k[0] = sct_pkg::KIND_OUT;
            end
            if (sep) begin
              if (mode_q == sct_pkg::MODE_WORD) begin
                slot_v[1] = 1'b1;
                slot_k[1] = sct_pkg::KIND_WEND;
              end
              mode_d = sct_pkg::MODE_IDLE;
              if (c == sct_pkg::CH_PIPE) begin
                slot_v[2] = 1'b1;
                slot_k[2] = sct_pkg::KIND_PIPE;
              end else if (c == sct_pkg::CH_SEMI) begin
                slot_v[2] = 1'b1;
                slot_k[2] = sct_pkg::KIND_SEMI;
              end else if (c == sct_pkg::CH_LT) begin
                slot_v[2] = 1'b1;
                slot_k[2] = sct_pkg::KIND_IN;
              end else if (c == sct_pkg::CH_GT) begin
                mode_d = sct_pkg::MODE_GT;
              end
            end else if (c == sct_pkg::CH_BSL) begin
              mode_d = sct_pkg::MODE_ESC;
            end else if (c == sct_pkg::CH_SQ) begin
              mode_d = sct_pkg::MODE_SQ;
            end else if (c == sct_pkg::CH_DQ) begin
              mode_d = sct_pkg::MODE_DQ;
            end else begin
              slot_v[2] = 1'b1;
              slot_c[2] = c;
              mode_d    = sct_pkg::MODE_WORD;
            end
          end
        end
      endcase
    end
  end

  // Pack the present events into the two result slots and mark the last one.
  always_comb begin
    cnt   = 2'd0;
    lex_o = '0;
    for (int i = 0; i < 3; i++) begin
      if (slot_v[i] && (cnt != 2'd2)) begin
        lex_o.res[cnt[0]].kind     = slot_k[i];
        lex_o.res[cnt[0]].char_out = slot_c[i];
        cnt = cnt + 2'd1;
      end
    end
    if (cnt != 2'd0) begin
      lex_o.res[cnt[1]].last = 1'b1;
    end
    lex_o.num = cnt;
  end

endmodule

/* sv/sct_res_fifo.sv */
module sct_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sct_pkg::lex_out_t  lex_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sct_pkg::res_t      out_data_o
);

  sct_pkg::res_t mem_q [sct_pkg::FIFO_DEPTH];

  logic [sct_pkg::PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [sct_pkg::CNT_W-1:0] count_q, count_d;
  logic [1:0]                num;
  logic                      pop;

  assign num         = push_i ? lex_i.num : 2'd0;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_q];
  // Room for a full two-event item, judged on the registered count.
  assign room_o      = (count_q <= sct_pkg::CNT_W'(sct_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_d    = wr_q + sct_pkg::PTR_W'(num);
    rd_d    = rd_q + sct_pkg::PTR_W'(pop);
    count_d = count_q + sct_pkg::CNT_W'(num) - sct_pkg::CNT_W'(pop);
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Event storage.
  always_ff @(posedge clk_i) begin
    if (num != 2'd0) begin
      mem_q[wr_q] <= lex_i.res[0];
    end
    if (num == 2'd2) begin
      mem_q[wr_q + sct_pkg::PTR_W'(1)] <= lex_i.res[1];
    end
  end

endmodule

/* sv/shell_command_tokenizer.sv */
// An accepted item passes through the input register and the lexer into the result
// queue, whose head is shown on the output port.
// Throughput: one item per cycle while items give at most one event and the output
// is not stalled; the output port delivers one event per cycle while not stalled.
// Reset: rst_ni clears the lexer mode to idle and empties the input and result stages.
module shell_command_tokenizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sct_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sct_pkg::res_t      out_data_o
);

  logic              in_valid_q, in_valid_d;
  sct_pkg::in_item_t in_item_q;
  logic              room;
  logic              step;
  logic              accept;
  sct_pkg::lex_out_t lex;

  assign step       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept || (in_valid_q && !step);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_data_i;
    end
  end

  sct_lex u_lex (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .lex_o  (lex)
  );

  sct_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .lex_i       (lex),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sv/sct_checker.sv */
module sct_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input sct_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sct_pkg::res_t      out_data_o
);

  // A stalled input item stays offered unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input item changed");

  // A stalled event stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled event changed");

  // The end event always closes the events of its item.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == sct_pkg::KIND_END) |-> out_data_o.last)
    else $error("end event not marked last");

  // Only word bytes carry a character.
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind != sct_pkg::KIND_BYTE) |->
    (out_data_o.char_out == 8'h00))
    else $error("non-byte event carries a character");

  // An event delivered without last is followed by the rest of its item.
  a_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o)
    else $error("item events split by a gap");

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned DRAIN_TAIL = 8;

  // An item waiting to be driven; drain makes the sender wait for all tokens first.
  typedef struct packed {
    logic              drain;
    sct_pkg::in_item_t it;
  } pend_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  sct_pkg::in_item_t in_data = '0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  sct_pkg::res_t     out_data;

  pend_t             byte_q[$];
  sct_pkg::res_t     token_q[$];
  sct_pkg::mode_e    lex_mode = sct_pkg::MODE_IDLE;
  sct_pkg::res_t     ev_buf[2];
  int                ev_n;
  logic              drain_next = 1'b0;

  int unsigned errors = 0;
  int unsigned in_accepted = 0;
  int unsigned ends_driven = 0;
  int unsigned tokens_seen = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_hold = 0;
  logic        long_hold_done = 1'b0;
  int unsigned idle_cycles = 0;

  shell_command_tokenizer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #4 clk = ~clk;

  // Token prediction.
  function automatic logic is_blank(logic [7:0] c);
    return (c == sct_pkg::CH_SPACE) || (c >= sct_pkg::CH_TAB && c <= sct_pkg::CH_CR);
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return is_blank(c) || c == sct_pkg::CH_PIPE || c == sct_pkg::CH_SEMI ||
           c == sct_pkg::CH_LT || c == sct_pkg::CH_GT;
  endfunction

  task automatic add_token(logic [3:0] k, logic [7:0] c);
    if (ev_n < 2) begin
      ev_buf[ev_n].kind = k;
      ev_buf[ev_n].char_out = (k == sct_pkg::KIND_BYTE) ? c : 8'h00;
      ev_buf[ev_n].last = 1'b0;
      ev_n++;
    end
  endtask

  // A byte seen while idle or inside an unquoted word.
  task automatic lex_plain(logic [7:0] c, logic in_word);
    if (is_sep(c)) begin
      if (in_word) add_token(sct_pkg::KIND_WEND, 8'h00);
      lex_mode = sct_pkg::MODE_IDLE;
      if (c == sct_pkg::CH_PIPE) add_token(sct_pkg::KIND_PIPE, 8'h00);
      else if (c == sct_pkg::CH_SEMI) add_token(sct_pkg::KIND_SEMI, 8'h00);
      else if (c == sct_pkg::CH_LT) add_token(sct_pkg::KIND_IN, 8'h00);
      else if (c == sct_pkg::CH_GT) lex_mode = sct_pkg::MODE_GT;
    end else if (c == sct_pkg::CH_BSL) begin
      lex_mode = sct_pkg::MODE_ESC;
    end else if (c == sct_pkg::CH_SQ) begin
      lex_mode = sct_pkg::MODE_SQ;
    end else if (c == sct_pkg::CH_DQ) begin
      lex_mode = sct_pkg::MODE_DQ;
    end else begin
      add_token(sct_pkg::KIND_BYTE, c);
      lex_mode = sct_pkg::MODE_WORD;
    end
  endtask

  task automatic lex_step(sct_pkg::in_item_t it);
    logic [7:0] c;
    c = it.char_in;
    ev_n = 0;
    if (it.command) begin
      case (lex_mode)
        sct_pkg::MODE_WORD: add_token(sct_pkg::KIND_WEND, 8'h00);
        sct_pkg::MODE_GT:   add_token(sct_pkg::KIND_OUT, 8'h00);
        sct_pkg::MODE_ESC, sct_pkg::MODE_SQ, sct_pkg::MODE_DQ, sct_pkg::MODE_DQESC:
          add_token(sct_pkg::KIND_ERR, 8'h00);
        default: ;
      endcase
      add_token(sct_pkg::KIND_END, 8'h00);
      lex_mode = sct_pkg::MODE_IDLE;
    end else begin
      case (lex_mode)
        sct_pkg::MODE_WORD: lex_plain(c, 1'b1);
        sct_pkg::MODE_ESC: begin
          add_token(sct_pkg::KIND_BYTE, c);
          lex_mode = sct_pkg::MODE_WORD;
        end
        sct_pkg::MODE_SQ: begin
          if (c == sct_pkg::CH_SQ) lex_mode = sct_pkg::MODE_WORD;
          else add_token(sct_pkg::KIND_BYTE, c);
        end
        sct_pkg::MODE_DQ: begin
          if (c == sct_pkg::CH_DQ) lex_mode = sct_pkg::MODE_WORD;
          else if (c == sct_pkg::CH_BSL) lex_mode = sct_pkg::MODE_DQESC;
          else add_token(sct_pkg::KIND_BYTE, c);
        end
        sct_pkg::MODE_DQESC: begin
          add_token(sct_pkg::KIND_BYTE, c);
          lex_mode = sct_pkg::MODE_DQ;
        end
        sct_pkg::MODE_GT: begin
          lex_mode = sct_pkg::MODE_IDLE;
          if (c == sct_pkg::CH_GT) begin
            add_token(sct_pkg::KIND_APP, 8'h00);
          end else begin
            add_token(sct_pkg::KIND_OUT, 8'h00);
            lex_plain(c, 1'b0);
          end
        end
        default: lex_plain(c, 1'b0);
      endcase
    end
    if (ev_n > 0) ev_buf[ev_n-1].last = 1'b1;
    for (int i = 0; i < ev_n; i++) token_q.push_back(ev_buf[i]);
  endtask

  // Stimulus helpers.
  task automatic push_byte(logic [7:0] c);
    pend_t p;
    p.drain = drain_next;
    p.it.command = 1'b0;
    p.it.char_in = c;
    drain_next = 1'b0;
    byte_q.push_back(p);
  endtask

  task automatic push_end();
    pend_t p;
    p.drain = drain_next;
    p.it.command = 1'b1;
    p.it.char_in = 8'($urandom);
    drain_next = 1'b0;
    byte_q.push_back(p);
  endtask

  function automatic logic is_special(logic [7:0] c);
    return is_sep(c) || c == sct_pkg::CH_BSL || c == sct_pkg::CH_SQ ||
           c == sct_pkg::CH_DQ;
  endfunction

  function automatic logic [7:0] pick_blank();
    logic [7:0] c;
    c = 8'($urandom_range(8, 13));
    return (c == 8'd8) ? sct_pkg::CH_SPACE : c;
  endfunction

  // Any byte, with shell metacharacters made frequent.
  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 11))
      0: return sct_pkg::CH_PIPE;
      1: return sct_pkg::CH_SEMI;
      2: return sct_pkg::CH_LT;
      3: return sct_pkg::CH_GT;
      4: return sct_pkg::CH_BSL;
      5: return sct_pkg::CH_SQ;
      6: return sct_pkg::CH_DQ;
      7: return pick_blank();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_word_byte();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h61, 8'h7A));
    c = 8'($urandom_range(0, 255));
    return is_special(c) ? 8'h61 + {4'h0, c[3:0]} : c;
  endfunction

  // One command line built from well-formed tokens, sometimes left broken.
  task automatic gen_line();
    int n;
    int len;
    logic [7:0] c;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 9))
        3: begin
          case ($urandom_range(0, 4))
            0: push_byte(sct_pkg::CH_PIPE);
            1: push_byte(sct_pkg::CH_SEMI);
            2: push_byte(sct_pkg::CH_LT);
            3: push_byte(sct_pkg::CH_GT);
            default: begin
              push_byte(sct_pkg::CH_GT);
              push_byte(sct_pkg::CH_GT);
            end
          endcase
        end
        4: begin
          push_byte(sct_pkg::CH_SQ);
          len = $urandom_range(0, 3);
          repeat (len) begin
            c = 8'($urandom_range(0, 255));
            push_byte((c == sct_pkg::CH_SQ) ? 8'h41 : c);
          end
          push_byte(sct_pkg::CH_SQ);
        end
        5: begin
          push_byte(sct_pkg::CH_DQ);
          len = $urandom_range(0, 3);
          repeat (len) begin
            c = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) begin
              push_byte(sct_pkg::CH_BSL);
              push_byte(c);
            end else begin
              push_byte((c == sct_pkg::CH_DQ || c == sct_pkg::CH_BSL) ? 8'h42 : c);
            end
          end
          push_byte(sct_pkg::CH_DQ);
        end
        6: begin
          push_byte(sct_pkg::CH_BSL);
          push_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          len = $urandom_range(1, 4);
          repeat (len) push_byte(pick_word_byte());
        end
      endcase
      if ($urandom_range(0, 3) != 0) push_byte(pick_blank());
    end
    // Occasionally leave an escape, quote or redirect open at end of input.
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: push_byte(sct_pkg::CH_BSL);
        1: push_byte(sct_pkg::CH_SQ);
        2: push_byte(sct_pkg::CH_DQ);
        3: begin
          push_byte(sct_pkg::CH_DQ);
          push_byte(sct_pkg::CH_BSL);
        end
        default: push_byte(sct_pkg::CH_GT);
      endcase
    end
    push_end();
  endtask

  task automatic gen_noise();
    int len;
    len = $urandom_range(3, 12);
    repeat (len) begin
      if ($urandom_range(0, 19) == 0) push_end();
      else push_byte(pick_noise());
    end
    push_end();
  endtask

  // Gap before the next item; some stretches run without any gap.
  function automatic int unsigned pick_gap(int unsigned count);
    int unsigned r;
    if ((count / 40) % 4 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Input driver: presents queued items and predicts tokens as they are accepted.
  always @(posedge clk or negedge rst_n) begin : p_drive
    int unsigned g;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      tx_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        lex_step(in_data);
        in_accepted++;
        if (in_data.command) ends_driven++;
        g = pick_gap(in_accepted);
      end else begin
        g = tx_gap;
      end
      if (g > 0) begin
        in_valid <= 1'b0;
        tx_gap <= g - 1;
      end else if (byte_q.size() > 0 && !(byte_q[0].drain && token_q.size() != 0)) begin
        in_valid <= 1'b1;
        in_data <= byte_q[0].it;
        byte_q.pop_front();
        tx_gap <= 0;
      end else begin
        in_valid <= 1'b0;
        tx_gap <= 0;
      end
    end
  end

  // Output monitor: checks each token and drives random stalls.
  always @(posedge clk or negedge rst_n) begin : p_check
    sct_pkg::res_t want;
    int unsigned r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        tokens_seen++;
        if (token_q.size() == 0) begin
          report($sformatf("token with none expected: kind %0d char %02h last %0b",
                           out_data.kind, out_data.char_out, out_data.last));
        end else begin
          want = token_q.pop_front();
          if (out_data.kind !== want.kind)
            report($sformatf("kind: expected %0d, got %0d", want.kind, out_data.kind));
          if (out_data.char_out !== want.char_out)
            report($sformatf("char_out: expected %02h, got %02h",
                             want.char_out, out_data.char_out));
          if (out_data.last !== want.last)
            report($sformatf("last: expected %0b, got %0b", want.last, out_data.last));
        end
      end
      // One long hold-off midway lets the block fill up and stall its input.
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold <= rx_hold - 1;
      end else if (!long_hold_done && in_accepted >= 250) begin
        long_hold_done <= 1'b1;
        out_stall <= 1'b1;
        rx_hold <= LONG_HOLD - 1;
      end else if ((tokens_seen / 50) % 4 == 2) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          if (r < 92) rx_hold <= $urandom_range(0, 2);
          else if (r < 99) rx_hold <= $urandom_range(4, 14);
          else rx_hold <= $urandom_range(19, 29);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // Directed part: operators, append lookahead, escapes, quotes, empty quotes,
    // byte zero, and end of input in each open state.
    push_byte(8'h61);
    push_byte(8'h00);
    push_byte(sct_pkg::CH_PIPE);
    push_byte(sct_pkg::CH_SEMI);
    push_byte(sct_pkg::CH_LT);
    push_byte(sct_pkg::CH_GT);
    push_byte(sct_pkg::CH_GT);
    push_byte(sct_pkg::CH_GT);
    push_byte(8'hFF);
    push_end();
    push_byte(sct_pkg::CH_BSL);
    push_byte(sct_pkg::CH_PIPE);
    push_byte(sct_pkg::CH_SQ);
    push_byte(sct_pkg::CH_SQ);
    push_byte(sct_pkg::CH_TAB);
    push_byte(sct_pkg::CH_SPACE);
    push_byte(sct_pkg::CH_DQ);
    push_byte(sct_pkg::CH_DQ);
    push_byte(sct_pkg::CH_CR);
    push_byte(sct_pkg::CH_DQ);
    push_byte(sct_pkg::CH_BSL);
    push_byte(sct_pkg::CH_DQ);
    push_end();
    push_byte(sct_pkg::CH_SQ);
    push_end();
    push_byte(sct_pkg::CH_BSL);
    push_end();
    push_byte(sct_pkg::CH_DQ);
    push_byte(sct_pkg::CH_BSL);
    push_end();
    push_byte(sct_pkg::CH_GT);
    push_end();
    push_end();

    // Random part: mostly well-formed lines, with some noise lines.
    drain_next = 1'b1;
    while (byte_q.size() < RANDOM_ITEMS + 32) begin
      if (byte_q.size() > 330 && byte_q.size() < 345) drain_next = 1'b1;
      if ($urandom_range(0, 6) == 0) gen_noise();
      else gen_line();
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (byte_q.size() != 0 || in_valid);
    while (token_q.size() != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);

    $display("Drove %0d items including %0d end-of-input commands; checked %0d tokens.",
             in_accepted, ends_driven, tokens_seen);
    $display("Lines mixed words, quotes, escapes, redirects and broken input under stalls.");
    if (errors == 0 && token_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/sct_pkg.sv
sv/sct_lex.sv
sv/sct_res_fifo.sv
sv/shell_command_tokenizer.sv
sv/sct_checker.sv
bench/tb.sv
